### design/csvt_pkg.sv
// ----------------------------------------------------------------------------
// csvt_pkg
// Shared types and constants for the CSV field tokenizer.
// ----------------------------------------------------------------------------
package csvt_pkg;

    localparam logic [7:0]  CHAR_CR = 8'd13;
    localparam logic [7:0]  CHAR_LF = 8'd10;

    localparam logic [7:0]  SEP_RESET     = 8'd44;
    localparam logic [7:0]  QUOTE_RESET   = 8'd34;
    localparam logic [15:0] MAXLEN_RESET  = 16'd1023;

    localparam int unsigned ADDR_BITS = 4;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_SEP    = 2'd0;
    localparam logic [1:0] REG_QUOTE  = 2'd1;
    localparam logic [1:0] REG_MAXLEN = 2'd2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic        has_byte;
        logic [7:0]  out_byte;
        logic        field_end;
        logic        row_end;
        logic [15:0] row_index;
        logic [9:0]  col_index;
        logic        truncated;
        logic        last_of_run;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  separator_char;
        logic [7:0]  quote_char;
        logic [15:0] max_field_len;
    } t_cfg;

endpackage

### design/csvt_regs.sv
// ----------------------------------------------------------------------------
// csvt_regs
// Configuration registers behind a simple APB-style port.
// ----------------------------------------------------------------------------
module csvt_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [csvt_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output csvt_pkg::t_cfg                 o_cfg
);

    csvt_pkg::t_cfg r_cfg;
    logic           wr_en;
    logic [1:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.separator_char <= csvt_pkg::SEP_RESET;
            r_cfg.quote_char     <= csvt_pkg::QUOTE_RESET;
            r_cfg.max_field_len  <= csvt_pkg::MAXLEN_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                csvt_pkg::REG_SEP:    r_cfg.separator_char <= pwdata[7:0];
                csvt_pkg::REG_QUOTE:  r_cfg.quote_char     <= pwdata[7:0];
                csvt_pkg::REG_MAXLEN: r_cfg.max_field_len  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            csvt_pkg::REG_SEP:    prdata = {24'd0, r_cfg.separator_char};
            csvt_pkg::REG_QUOTE:  prdata = {24'd0, r_cfg.quote_char};
            csvt_pkg::REG_MAXLEN: prdata = {16'd0, r_cfg.max_field_len};
            default:              prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

### design/csvt_parser.sv
// ----------------------------------------------------------------------------
// csvt_parser
// Parse state and the per-word step logic: one word in, at most one result.
// ----------------------------------------------------------------------------
module csvt_parser #(
    parameter int ROW_BITS = 16,
    parameter int COL_BITS = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  csvt_pkg::t_in_item  i_item,
    input  csvt_pkg::t_cfg      i_cfg,
    output logic                o_res_valid,
    output csvt_pkg::t_out_item o_res
);

    typedef enum logic [1:0] {
        MODE_START  = 2'd0,
        MODE_PLAIN  = 2'd1,
        MODE_QUOTED = 2'd2,
        MODE_QCLOSE = 2'd3
    } t_mode;

    t_mode               r_mode, n_mode;
    logic                r_open, n_open;
    logic                r_after_cr, n_after_cr;
    logic                r_line, n_line;
    logic [15:0]         r_len, n_len;
    logic                r_trunc, n_trunc;
    logic [ROW_BITS-1:0] r_row, n_row;
    logic [COL_BITS-1:0] r_col, n_col;

    logic [7:0]  b;
    logic        is_brk;
    logic        is_sep;
    logic        is_quote;
    logic        do_content;
    logic        do_emit;
    logic        emit_has;
    logic        emit_fe;
    logic        emit_re;
    logic [15:0] row_ext;
    logic [9:0]  col_ext;

    assign b        = i_item.in_byte;
    assign is_brk   = (b == csvt_pkg::CHAR_CR) || (b == csvt_pkg::CHAR_LF);
    assign is_sep   = (b == i_cfg.separator_char);
    assign is_quote = (b == i_cfg.quote_char);
    assign row_ext  = 16'(r_row);
    assign col_ext  = 10'(r_col);

    always_comb begin
        n_mode     = r_mode;
        n_open     = r_open;
        n_after_cr = r_after_cr;
        n_line     = r_line;
        n_len      = r_len;
        n_trunc    = r_trunc;
        n_row      = r_row;
        n_col      = r_col;
        do_content = 1'b0;
        do_emit    = 1'b0;
        emit_has   = 1'b0;
        emit_fe    = 1'b0;
        emit_re    = 1'b0;

        if (i_item.end_of_text) begin
            do_emit    = r_line || r_open;
            emit_fe    = r_open;
            emit_re    = 1'b1;
            n_mode     = MODE_START;
            n_open     = 1'b0;
            n_after_cr = 1'b0;
            n_line     = 1'b0;
            n_len      = 16'd0;
            n_trunc    = 1'b0;
            n_row      = '0;
            n_col      = '0;
        end else begin
            n_after_cr = 1'b0;
            // An LF that directly follows a row-ending CR is swallowed.
            if (!(r_after_cr && b == csvt_pkg::CHAR_LF)) begin
                if (r_mode == MODE_QUOTED) begin
                    if (is_quote) begin
                        n_mode = MODE_QCLOSE;
                    end else begin
                        do_content = 1'b1;
                    end
                end else if (r_mode == MODE_QCLOSE && is_quote) begin
                    n_mode     = MODE_QUOTED;
                    do_content = 1'b1;
                end else if (is_brk) begin
                    do_emit    = 1'b1;
                    emit_fe    = r_open;
                    emit_re    = 1'b1;
                    if (!(&r_row)) begin
                        n_row = r_row + 1'b1;
                    end
                    n_col      = '0;
                    n_mode     = MODE_START;
                    n_open     = 1'b0;
                    n_len      = 16'd0;
                    n_trunc    = 1'b0;
                    n_line     = 1'b0;
                    n_after_cr = (b == csvt_pkg::CHAR_CR);
                end else if (is_sep) begin
                    do_emit = 1'b1;
                    emit_fe = 1'b1;
                    if (!(&r_col)) begin
                        n_col = r_col + 1'b1;
                    end
                    n_mode  = MODE_START;
                    n_open  = 1'b0;
                    n_len   = 16'd0;
                    n_trunc = 1'b0;
                    n_line  = 1'b1;
                end else if (r_mode == MODE_START && is_quote) begin
                    n_mode = MODE_QUOTED;
                    n_open = 1'b1;
                    n_line = 1'b1;
                end else begin
                    n_mode     = MODE_PLAIN;
                    do_content = 1'b1;
                end
            end

            if (do_content) begin
                n_line = 1'b1;
                n_open = 1'b1;
                if (r_len >= i_cfg.max_field_len) begin
                    n_trunc = 1'b1;
                end else begin
                    n_len    = r_len + 16'd1;
                    do_emit  = 1'b1;
                    emit_has = 1'b1;
                end
            end
        end
    end

    // Results carry the row, column and truncation state seen before the update.
    always_comb begin
        o_res_valid       = i_fire && do_emit;
        o_res.has_byte    = emit_has;
        o_res.out_byte    = emit_has ? b : 8'd0;
        o_res.field_end   = emit_fe;
        o_res.row_end     = emit_re;
        o_res.row_index   = row_ext;
        o_res.col_index   = col_ext;
        o_res.truncated   = r_trunc;
        o_res.last_of_run = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_START;
            r_open     <= 1'b0;
            r_after_cr <= 1'b0;
            r_line     <= 1'b0;
            r_len      <= 16'd0;
            r_trunc    <= 1'b0;
            r_row      <= '0;
            r_col      <= '0;
        end else if (i_fire) begin
            r_mode     <= n_mode;
            r_open     <= n_open;
            r_after_cr <= n_after_cr;
            r_line     <= n_line;
            r_len      <= n_len;
            r_trunc    <= n_trunc;
            r_row      <= n_row;
            r_col      <= n_col;
        end
    end

endmodule

### design/csv_field_tokenizer_core.sv
// ----------------------------------------------------------------------------
// csv_field_tokenizer_core
// A word passes from the input register r_in via the parse step into r_out.
// It takes one word per cycle unless a stalled result holds the parse step.
// Each word yields at most one result; words that yield none leave r_out empty.
// Reset (i_rst_n low, synchronous) empties the pipeline, clears the parser
// and loads the register defaults.
// ----------------------------------------------------------------------------
module csv_field_tokenizer_core #(
    parameter int ROW_BITS = 16,
    parameter int COL_BITS = 10
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  csvt_pkg::t_in_item             i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output csvt_pkg::t_out_item            o_out_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [csvt_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    csvt_pkg::t_cfg      cfg;
    csvt_pkg::t_in_item  r_in;
    logic                r_in_valid;
    csvt_pkg::t_out_item r_out;
    logic                r_out_valid;
    csvt_pkg::t_out_item res;
    logic                res_valid;
    logic                adv;
    logic                fire;
    logic                in_acc;

    // The parse stage moves whenever the result register is free or being taken.
    assign adv        = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && adv;
    assign o_in_stall = r_in_valid && !adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    csvt_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    csvt_parser #(
        .ROW_BITS (ROW_BITS),
        .COL_BITS (COL_BITS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (r_in),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (adv || !r_in_valid) begin
            r_in_valid <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### design/csvt_checker.sv
// ----------------------------------------------------------------------------
// csvt_checker
// Port-level checks for the tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module csvt_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input csvt_pkg::t_out_item o_out_data
);

    // A stalled result word stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result word changed while stalled");

    // Nothing comes out in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result shown right after reset");

    // A content byte never carries field or row marks, and a mark-only word has no byte.
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.has_byte && !o_out_data.field_end && !o_out_data.row_end)
            || (!o_out_data.has_byte && o_out_data.out_byte == 8'd0
                && (o_out_data.field_end || o_out_data.row_end)))
        else $error("malformed result word");

    // Every input causes at most one result, so each result ends its run.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.last_of_run)
        else $error("result word without last_of_run");

endmodule

bind csv_field_tokenizer_core csvt_checker u_csvt_checker (.*);
